FILE: hw/rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared constants and the sequencer state type for the Miller-Rabin round.
// ----------------------------------------------------------------------------
package mrr_pkg;

   localparam int FIELD_W   = 62;  // width of the candidate and witness ports
   localparam int DEF_WIDTH = 62;  // default datapath width

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_REDUCE,
      ST_POW_STEP,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_CHECK,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_FINISH
   } mrr_state_type;

endpackage

FILE: hw/rtl/mrr_modred.sv
// ----------------------------------------------------------------------------
// mrr_modred
// Bit-serial restoring reduction: remainder of a dividend modulo n, one
// dividend bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module mrr_modred
   import mrr_pkg::*;
#(
   parameter int WIDTH = DEF_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, div_ff[WIDTH-1]};
      if (trial >= {1'b0, modulus}) begin
         trial = trial - {1'b0, modulus};
      end
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = dividend;
      end else if (busy_ff) begin
         rem_in = trial[WIDTH-1:0];
         div_in = {div_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/mrr_modmul.sv
// ----------------------------------------------------------------------------
// mrr_modmul
// Bit-serial shift-and-add modular multiplier: one multiplier bit per cycle,
// least significant first, accumulator and multiplicand kept below n.
// ----------------------------------------------------------------------------
module mrr_modmul
   import mrr_pkg::*;
#(
   parameter int WIDTH = DEF_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_x,
   input  logic [WIDTH-1:0] op_y,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH:0]   acc_sum;
   logic [WIDTH:0]   dbl_sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      // both sums stay below 2n, so one conditional subtract reduces them
      acc_sum = {1'b0, acc_ff} + {1'b0, x_ff};
      if (acc_sum >= {1'b0, modulus}) begin
         acc_sum = acc_sum - {1'b0, modulus};
      end
      dbl_sum = {x_ff, 1'b0};
      if (dbl_sum >= {1'b0, modulus}) begin
         dbl_sum = dbl_sum - {1'b0, modulus};
      end
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         x_in    = op_x;
         y_in    = op_y;
      end else if (busy_ff) begin
         if (y_ff[0]) begin
            acc_in = acc_sum[WIDTH-1:0];
         end
         x_in   = dbl_sum[WIDTH-1:0];
         y_in   = {1'b0, y_ff[WIDTH-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: hw/rtl/miller_rabin_round.sv
// ----------------------------------------------------------------------------
// miller_rabin_round
// One Miller-Rabin round for a candidate and a witness, bit-serial datapath.
// ----------------------------------------------------------------------------
// One item is worked at a time. Candidates below 4 go straight to the finish
// state. Otherwise the sequencer strips the trailing zeros of n-1 (s of
// them), reduces the witness modulo n in the serial reducer, then runs one
// or two products per bit of the odd part d and s-1 squarings at most, each
// product in the single shared bit-serial multiplier. A new request beat is
// taken while a finished result beat still waits on the response side; only
// the low WIDTH bits of the fields are used.
module miller_rabin_round
   import mrr_pkg::*;
#(
   parameter int WIDTH = DEF_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [FIELD_W-1:0] req_candidate,
   input  logic [FIELD_W-1:0] req_witness,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_probable_prime
);

   localparam int SW = $clog2(WIDTH);

   mrr_state_type    state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] nm1_ff, nm1_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [SW-1:0]    s_ff, s_in;
   logic             res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pp_ff, rsp_pp_in;

   logic [WIDTH-1:0] cand;
   logic             red_start, red_done;
   logic [WIDTH-1:0] red_rem;
   logic             mul_start, mul_done;
   logic [WIDTH-1:0] mul_x, mul_y, mul_res;

   assign cand = req_candidate[WIDTH-1:0];

   mrr_modred #(.WIDTH(WIDTH)) u_red (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .dividend  (a_ff),
      .modulus   (n_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   mrr_modmul #(.WIDTH(WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_x    (mul_x),
      .op_y    (mul_y),
      .modulus (n_ff),
      .done    (mul_done),
      .product (mul_res)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      nm1_in       = nm1_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      b_in         = b_ff;
      s_in         = s_ff;
      res_in       = res_ff;
      rsp_pp_in    = rsp_pp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      red_start    = 1'b0;
      mul_start    = 1'b0;
      mul_x        = b_ff;
      mul_y        = b_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in   = cand;
               a_in   = req_witness[WIDTH-1:0];
               nm1_in = cand - WIDTH'(1);
               d_in   = cand - WIDTH'(1);
               s_in   = '0;
               if (cand < WIDTH'(2)) begin
                  res_in   = 1'b0;
                  state_in = ST_FINISH;
               end else if (cand < WIDTH'(4)) begin
                  res_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (d_ff[0]) begin
               red_start = 1'b1;
               state_in  = ST_REDUCE;
            end else begin
               d_in = {1'b0, d_ff[WIDTH-1:1]};
               s_in = s_ff + 1'b1;
            end
         end
         ST_REDUCE: begin
            if (red_done) begin
               b_in     = red_rem;
               r_in     = WIDTH'(1);
               state_in = ST_POW_STEP;
            end
         end
         ST_POW_STEP: begin
            mul_start = 1'b1;
            if (d_ff[0]) begin
               mul_x    = r_ff;
               state_in = ST_POW_MUL;
            end else begin
               state_in = ST_POW_SQR;
            end
         end
         ST_POW_MUL: begin
            if (mul_done) begin
               r_in      = mul_res;
               mul_start = 1'b1;
               state_in  = ST_POW_SQR;
            end
         end
         ST_POW_SQR: begin
            if (mul_done) begin
               b_in = mul_res;
               d_in = {1'b0, d_ff[WIDTH-1:1]};
               if (d_ff[WIDTH-1:1] == '0) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_POW_STEP;
               end
            end
         end
         ST_CHECK: begin
            if (r_ff == WIDTH'(1) || r_ff == nm1_ff) begin
               res_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (s_ff <= SW'(1)) begin
               res_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               // s-1 squarings remain
               s_in     = s_ff - 1'b1;
               state_in = ST_SQ_START;
            end
         end
         ST_SQ_START: begin
            mul_start = 1'b1;
            mul_x     = r_ff;
            mul_y     = r_ff;
            state_in  = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (mul_done) begin
               r_in = mul_res;
               if (mul_res == nm1_ff) begin
                  res_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (mul_res == WIDTH'(1) || s_ff == SW'(1)) begin
                  res_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  s_in     = s_ff - 1'b1;
                  state_in = ST_SQ_START;
               end
            end
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pp_in    = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff      <= n_in;
      a_ff      <= a_in;
      nm1_ff    <= nm1_in;
      d_ff      <= d_in;
      r_ff      <= r_in;
      b_ff      <= b_in;
      s_ff      <= s_in;
      res_ff    <= res_in;
      rsp_pp_ff <= rsp_pp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probable_prime = rsp_pp_ff;

endmodule
